// ----- hw/rtl/alz_pkg.sv -----
package alz_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BRANCHES   = 4;
    localparam int unsigned STEP_IDX_W = 3;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned DATA_W     = 2 * WORD_W * BRANCHES;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd4;

    // one branch word: x in the upper half, y in the lower half
    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
    } xy_t;

    // branch 0 in the lowest bits
    typedef xy_t [BRANCHES-1:0] state_t;

    // step constants, the first four also serve as the branch constants
    localparam logic [7:0][WORD_W-1:0] STEP_CONST = {
        32'hC2B3293D, 32'hCFBFA1C8, 32'h4F7C7B57, 32'hBB1185EB,
        32'h324E7738, 32'h38B4DA56, 32'hBF715880, 32'hB7E15162
    };

    function automatic logic [WORD_W-1:0] ror32(input logic [WORD_W-1:0] v,
                                                input int unsigned n);
        logic [2*WORD_W-1:0] t;
        t = {v, v} >> n;
        return t[WORD_W-1:0];
    endfunction

    // one arx round: a += ror(b, ra); b ^= ror(a, rb); a ^= c
    function automatic xy_t alz_round(input xy_t v, input logic [WORD_W-1:0] c,
                                      input int unsigned ra, input int unsigned rb);
        xy_t r;
        r.x = v.x + ror32(v.y, ra);
        r.y = v.y ^ ror32(r.x, rb);
        r.x = r.x ^ c;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] ell(input logic [WORD_W-1:0] v);
        return ror32(v ^ {v[15:0], 16'h0000}, 16);
    endfunction

endpackage

// ----- hw/rtl/alz_half_stage.sv -----
module alz_half_stage (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic                                in_valid,
    input  alz_pkg::state_t                     in_state,
    input  logic                                active,
    input  logic                                first_half,
    input  logic [alz_pkg::STEP_IDX_W-1:0]      step_idx,
    output logic                                out_valid,
    output alz_pkg::state_t                     out_state
);

    logic                valid_reg;
    alz_pkg::state_t     state_reg;
    alz_pkg::state_t     state_next;
    alz_pkg::state_t     inj;
    alz_pkg::state_t     rnd;
    logic [alz_pkg::WORD_W-1:0] tx;
    logic [alz_pkg::WORD_W-1:0] ty;

    always_comb begin
        inj = in_state;
        // constant and step index injection only in the first half of a step
        if (first_half) begin
            inj[0].y = in_state[0].y ^ alz_pkg::STEP_CONST[step_idx];
            inj[1].y = in_state[1].y ^
                       {{(alz_pkg::WORD_W-alz_pkg::STEP_IDX_W){1'b0}}, step_idx};
        end
        for (int i = 0; i < alz_pkg::BRANCHES; i++) begin
            if (first_half) begin
                rnd[i] = alz_pkg::alz_round(inj[i], alz_pkg::STEP_CONST[i], 31, 24);
                rnd[i] = alz_pkg::alz_round(rnd[i], alz_pkg::STEP_CONST[i], 17, 17);
            end else begin
                rnd[i] = alz_pkg::alz_round(inj[i], alz_pkg::STEP_CONST[i], 0, 31);
                rnd[i] = alz_pkg::alz_round(rnd[i], alz_pkg::STEP_CONST[i], 24, 16);
            end
        end
        tx = alz_pkg::ell(rnd[0].x ^ rnd[1].x);
        ty = alz_pkg::ell(rnd[0].y ^ rnd[1].y);
        if (!active) begin
            state_next = in_state;
        end else if (first_half) begin
            state_next = rnd;
        end else begin
            // linear layer with branch swap
            state_next[0].x = rnd[3].x ^ rnd[1].x ^ ty;
            state_next[0].y = rnd[3].y ^ rnd[1].y ^ tx;
            state_next[1].x = rnd[2].x ^ rnd[0].x ^ ty;
            state_next[1].y = rnd[2].y ^ rnd[0].y ^ tx;
            state_next[2]   = rnd[0];
            state_next[3]   = rnd[1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// ----- hw/rtl/alzette_permutation_256_core.sv -----
// every state runs through all steps of the pipeline, independent of step_count;
//   unused steps pass the state through unchanged
// throughput: one state per cycle unless m_tready stalls; two pipeline stages per step
// reset: aresetn synchronous active low, clears all stage valid bits and loads
//   step_count with 4; payload registers are not reset
module alzette_permutation_256_core #(
    parameter int unsigned MAX_STEPS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration, step_count register
    input  logic                              cfg_we,
    input  logic [alz_pkg::COUNT_W-1:0]       cfg_wdata,
    // input state stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // branch0_in, branch1_in, branch2_in, branch3_in (64 bits each, from bit 0 up)
    input  logic [alz_pkg::DATA_W-1:0]        s_tdata,
    // permuted state stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // branch0_out, branch1_out, branch2_out, branch3_out (64 bits each, from bit 0 up)
    output logic [alz_pkg::DATA_W-1:0]        m_tdata
);

    localparam int unsigned NUM_STAGES = 2 * MAX_STEPS;

    logic [alz_pkg::COUNT_W-1:0] step_count_reg;
    logic [alz_pkg::COUNT_W-1:0] steps_eff;

    logic [NUM_STAGES-1:0]       stage_valid;
    logic [NUM_STAGES:0]         stage_ready;
    alz_pkg::state_t             stage_state [NUM_STAGES];

    // step count register; the user must write it only while the pipeline is empty, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg <= alz_pkg::COUNT_RESET;
        end else if (cfg_we) begin
            step_count_reg <= cfg_wdata;
        end
    end

    // counts above the pipeline depth saturate
    assign steps_eff = (step_count_reg > alz_pkg::COUNT_W'(MAX_STEPS)) ?
                       alz_pkg::COUNT_W'(MAX_STEPS) : step_count_reg;

    // ready chain: a stage takes new data when it is empty or drains this cycle,
    // so bubbles collapse; ready runs combinationally from m_tready to s_tready
    assign stage_ready[NUM_STAGES] = m_tready;

    genvar g;
    generate
        for (g = 0; g < NUM_STAGES; g++) begin : g_stage
            logic                 in_valid;
            alz_pkg::state_t      in_state;
            logic                 active;

            assign stage_ready[g] = !stage_valid[g] || stage_ready[g+1];

            if (g == 0) begin : g_first
                assign in_valid = s_tvalid;
                assign in_state = alz_pkg::state_t'(s_tdata);
            end else begin : g_rest
                assign in_valid = stage_valid[g-1];
                assign in_state = stage_state[g-1];
            end

            // step g/2 runs only if it lies below the configured count
            assign active = (alz_pkg::COUNT_W'(g / 2) < steps_eff);

            alz_half_stage u_half (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .load       (stage_ready[g]),
                .in_valid   (in_valid),
                .in_state   (in_state),
                .active     (active),
                .first_half ((g % 2) == 0),
                .step_idx   (alz_pkg::STEP_IDX_W'(g / 2)),
                .out_valid  (stage_valid[g]),
                .out_state  (stage_state[g])
            );
        end
    endgenerate

    assign s_tready = stage_ready[0];
    assign m_tvalid = stage_valid[NUM_STAGES-1];
    assign m_tdata  = alz_pkg::DATA_W'(stage_state[NUM_STAGES-1]);

    // input can only be refused when every stage holds a state and the sink stalls
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&stage_valid) && !m_tready)
        else $error("input refused while pipeline has room");

    // an accepting sink must let the whole pipeline move
    a_sink_ready_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("pipeline stalled with ready sink");

    // a refused result stays put in the output stage
    a_out_stage_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stage_valid[NUM_STAGES-1] && !m_tready |=>
            stage_valid[NUM_STAGES-1] && $stable(stage_state[NUM_STAGES-1]))
        else $error("output stage changed while stalled");

endmodule
